>>> src/mbbs_pkg.sv
// shared types and constants for the model-biased binary search core
package mbbs_pkg;

  localparam int unsigned KEY_W   = 64;   // table key width
  localparam int unsigned IDX_W   = 12;   // entry_index and position width
  localparam int unsigned BOUND_W = 21;   // signed bound and prediction width
  localparam int unsigned WIN_W   = 22;   // signed working width of the window
  localparam int unsigned PRB_W   = 5;    // probe counter width
  localparam int unsigned KCNT_W  = 13;   // key_count register width

  localparam logic [KCNT_W-1:0] KEY_COUNT_RESET = 13'd4096;
  localparam logic [PRB_W-1:0]  PROBE_MAX       = 5'd31;

  // item kinds carried in tuser
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // register index from paddr[2]
  localparam logic REG_KEY_COUNT = 1'b0;

  // widths of the stream payloads
  localparam int unsigned IN_TDATA_W  = 208;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic write;    // store a load beat into the table
    logic start;    // latch a search beat and clamp its window
    logic probe;    // issue one table read
    logic compare;  // evaluate the read entry
    logic emit;     // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic win_ok;    // raw window on the input is not empty
    logic cont;      // another probe is due
    logic hit;       // read entry equals the key
    logic out_busy;  // output register still holds an untaken result
  } status_t;

endpackage

>>> src/model_biased_binary_search_core.sv
// sequence: a load beat is written at its accept edge and gives no result; each search probe
// is a read state and then a compare state, a hit or a final end test that finds the window
// empty ends the search, and an inverted raw window ends it without any probe
// flow: one item at a time; a search, of at most 13 probes, ends before the next item is
// accepted; an untaken result in the output register holds the next search in its done state
// reset: asynchronous active low; clears control state, key_count to 4096, table left as is
module model_biased_binary_search_core #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // entry_index[11:0], entry_key[75:12], search_key[139:76],
  // predicted_position[160:140], low_bound[181:161], high_bound[202:182], zero pad
  input  logic [mbbs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // mode[0]
  input  logic                                 s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // position[11:0], probe_count[16:12], zero pad
  output logic [mbbs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // found[0]
  output logic                                 m_axis_tuser,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  mbbs_pkg::cmd_t    cmd;
  mbbs_pkg::status_t status;

  logic [mbbs_pkg::KCNT_W-1:0] key_count_q;
  logic                        cfg_wr;

  logic [mbbs_pkg::IDX_W-1:0]   position;
  logic [mbbs_pkg::PRB_W-1:0]   probe_count;

  // key_count register, written on the access phase of an apb write
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == mbbs_pkg::REG_KEY_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= mbbs_pkg::KEY_COUNT_RESET;
    end else if (cfg_wr) begin
      key_count_q <= pwdata[mbbs_pkg::KCNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == mbbs_pkg::REG_KEY_COUNT) ? 32'(key_count_q) : '0;

  // sequencer
  mbbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  // table, window and result register
  mbbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .key_count_i          (key_count_q),
    .entry_index_i        (s_axis_tdata[11:0]),
    .entry_key_i          (s_axis_tdata[75:12]),
    .search_key_i         (s_axis_tdata[139:76]),
    .predicted_position_i (s_axis_tdata[160:140]),
    .low_bound_i          (s_axis_tdata[181:161]),
    .high_bound_i         (s_axis_tdata[202:182]),
    .out_ready_i          (m_axis_tready),
    .out_valid_o          (m_axis_tvalid),
    .found_o              (m_axis_tuser),
    .position_o           (position),
    .probe_count_o        (probe_count)
  );

  assign m_axis_tdata = {7'b0, probe_count, position};

endmodule

>>> src/mbbs_ctrl.sv
// search sequencer: state machine that drives the datapath
module mbbs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_mode_i,
  input  mbbs_pkg::status_t status_i,
  output mbbs_pkg::cmd_t  cmd_o,
  output logic            in_ready_o
);

  mbbs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbbs_pkg::ST_IDLE: begin
        if (in_valid_i && (in_mode_i == mbbs_pkg::MODE_SEARCH)) begin
          state_d = status_i.win_ok ? mbbs_pkg::ST_PROBE : mbbs_pkg::ST_DONE;
        end
      end
      mbbs_pkg::ST_PROBE: begin
        state_d = status_i.cont ? mbbs_pkg::ST_CMP : mbbs_pkg::ST_DONE;
      end
      mbbs_pkg::ST_CMP: begin
        state_d = status_i.hit ? mbbs_pkg::ST_DONE : mbbs_pkg::ST_PROBE;
      end
      mbbs_pkg::ST_DONE: begin
        if (!status_i.out_busy) state_d = mbbs_pkg::ST_IDLE;
      end
      default: state_d = mbbs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mbbs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == mbbs_pkg::MODE_SEARCH) cmd_o.start = 1'b1;
          else                                    cmd_o.write = 1'b1;
        end
      end
      mbbs_pkg::ST_PROBE: begin
        cmd_o.probe = status_i.cont;
      end
      mbbs_pkg::ST_CMP: begin
        cmd_o.compare = 1'b1;
      end
      mbbs_pkg::ST_DONE: begin
        cmd_o.emit = !status_i.out_busy;
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> src/mbbs_dp.sv
// search datapath: key table, window registers, compare and result register
module mbbs_dp #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mbbs_pkg::cmd_t                       cmd_i,
  output mbbs_pkg::status_t                    status_o,
  input  logic [mbbs_pkg::KCNT_W-1:0]          key_count_i,
  input  logic [mbbs_pkg::IDX_W-1:0]           entry_index_i,
  input  logic [mbbs_pkg::KEY_W-1:0]           entry_key_i,
  input  logic [mbbs_pkg::KEY_W-1:0]           search_key_i,
  input  logic signed [mbbs_pkg::BOUND_W-1:0]  predicted_position_i,
  input  logic signed [mbbs_pkg::BOUND_W-1:0]  low_bound_i,
  input  logic signed [mbbs_pkg::BOUND_W-1:0]  high_bound_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic                                 found_o,
  output logic [mbbs_pkg::IDX_W-1:0]           position_o,
  output logic [mbbs_pkg::PRB_W-1:0]           probe_count_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IW = (AW > mbbs_pkg::IDX_W) ? AW : mbbs_pkg::IDX_W;
  localparam int unsigned WW = mbbs_pkg::WIN_W;
  localparam logic [WW-1:0] DEPTH_W = WW'(TABLE_DEPTH);
  localparam logic [mbbs_pkg::PRB_W-1:0] PRB_ONE = {{(mbbs_pkg::PRB_W-1){1'b0}}, 1'b1};

  logic [mbbs_pkg::KEY_W-1:0] key_mem_q [TABLE_DEPTH];
  logic [mbbs_pkg::KEY_W-1:0] rdata_q;
  logic [mbbs_pkg::KEY_W-1:0] key_q;

  logic signed [WW-1:0] lo_q, hi_q, pred_q, m_q;
  logic signed [WW-1:0] lo_d, hi_d, pred_d;
  logic                 first_q;
  logic                 found_q;
  logic [mbbs_pkg::IDX_W-1:0] pos_q;
  logic [mbbs_pkg::PRB_W-1:0] probes_q;

  logic                       out_valid_q;
  logic                       out_found_q;
  logic [mbbs_pkg::IDX_W-1:0] out_pos_q;
  logic [mbbs_pkg::PRB_W-1:0] out_probes_q;

  logic [WW-1:0]        cnt_ext;
  logic signed [WW-1:0] last_idx;
  logic signed [WW-1:0] lo_raw, hi_raw, pred_raw;
  logic signed [WW-1:0] diff, mid, addr;
  logic [IW-1:0]        widx;
  logic                 load_ok;

  // last valid index from key_count: zero acts as one, clipped to the depth
  assign cnt_ext = WW'(key_count_i);
  always_comb begin
    if (cnt_ext == '0)            last_idx = '0;
    else if (cnt_ext > DEPTH_W)   last_idx = $signed(DEPTH_W - WW'(1));
    else                          last_idx = $signed(cnt_ext - WW'(1));
  end

  assign lo_raw   = WW'(low_bound_i);
  assign hi_raw   = WW'(high_bound_i);
  assign pred_raw = WW'(predicted_position_i);

  // clamp the window and the first probe into the table
  always_comb begin
    lo_d   = (lo_raw < 0) ? '0 : lo_raw;
    hi_d   = (hi_raw > last_idx) ? last_idx : hi_raw;
    pred_d = pred_raw;
    if (pred_raw < 0)             pred_d = '0;
    else if (pred_raw > last_idx) pred_d = last_idx;
  end

  // midpoint of the remaining window
  assign diff = hi_q - lo_q;
  assign mid  = lo_q + (diff >>> 1);
  assign addr = first_q ? pred_q : mid;

  assign widx    = IW'(entry_index_i);
  assign load_ok = (32'(entry_index_i) < 32'(TABLE_DEPTH));

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && load_ok) key_mem_q[widx[AW-1:0]] <= entry_key_i;
    if (cmd_i.probe)            rdata_q <= key_mem_q[addr[AW-1:0]];
  end

  // window and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= 1'b0;
      found_q  <= 1'b0;
      probes_q <= '0;
    end else begin
      if (cmd_i.start) begin
        first_q  <= 1'b1;
        found_q  <= 1'b0;
        probes_q <= '0;
      end
      if (cmd_i.probe) begin
        first_q <= 1'b0;
        if (probes_q != mbbs_pkg::PROBE_MAX) probes_q <= probes_q + PRB_ONE;
      end
      if (cmd_i.compare && (rdata_q == key_q)) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q  <= search_key_i;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      pred_q <= pred_d;
      pos_q  <= '0;
    end
    if (cmd_i.probe) m_q <= addr;
    if (cmd_i.compare) begin
      if (rdata_q == key_q)     pos_q <= m_q[mbbs_pkg::IDX_W-1:0];
      else if (rdata_q < key_q) lo_q  <= m_q + WW'(1);
      else                      hi_q  <= m_q - WW'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_found_q  <= found_q;
      out_pos_q    <= pos_q;
      out_probes_q <= probes_q;
    end
  end

  assign status_o.win_ok   = (lo_raw <= hi_raw);
  assign status_o.cont     = first_q || (lo_q <= hi_q);
  assign status_o.hit      = (rdata_q == key_q);
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign position_o    = out_pos_q;
  assign probe_count_o = out_probes_q;

endmodule

>>> tb/sv/tb_model_biased_binary_search_core.sv
// self-checking testbench for the model-biased binary search core
module tb_model_biased_binary_search_core;

  localparam int unsigned IDX_W       = mbbs_pkg::IDX_W;
  localparam int unsigned KEY_W       = mbbs_pkg::KEY_W;
  localparam int unsigned BOUND_W     = mbbs_pkg::BOUND_W;
  localparam int unsigned PRB_W       = mbbs_pkg::PRB_W;
  localparam int unsigned KCNT_W      = mbbs_pkg::KCNT_W;
  localparam int unsigned IN_TDATA_W  = mbbs_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = mbbs_pkg::OUT_TDATA_W;

  localparam int unsigned DEPTH           = 4096;
  localparam int unsigned STALL_LIMIT     = 4000;  // cycles with no beat, no register access
  localparam int unsigned SETTLE_CYCLES   = 40;    // covers the longest search, of 13 probes
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned BEATS_PER_PHASE = 90;
  localparam int unsigned REFILL_MAX      = 160;   // small tables are reloaded sorted per phase
  localparam int          FILL_SPAN       = 256;   // leading slots written by the first phase

  // one input beat, fields as the block sees them
  typedef struct {
    logic                      mode;
    logic [IDX_W-1:0]          entry_index;
    logic [KEY_W-1:0]          entry_key;
    logic [KEY_W-1:0]          search_key;
    logic signed [BOUND_W-1:0] predicted_position;
    logic signed [BOUND_W-1:0] low_bound;
    logic signed [BOUND_W-1:0] high_bound;
  } query_t;

  // one result beat
  typedef struct {
    logic             found;
    logic [IDX_W-1:0] position;
    logic [PRB_W-1:0] probe_count;
  } result_t;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_SEARCH,
    ROW_KEY_COUNT
  } row_kind_e;

  // one line of the directed table
  typedef struct {
    row_kind_e   kind;
    int          count;  // key_count value for a register row
    query_t      beat;
    bit          typed;  // result written out by hand instead of predicted
    result_t     want;
  } stim_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [2:0]             paddr         = '0;
  logic [31:0]            pwdata        = '0;
  logic [31:0]            prdata;
  logic                   pready;

  // shadow of the key table and of key_count, updated at the accepting edge
  logic [KEY_W-1:0]  key_store [DEPTH];
  logic [KCNT_W-1:0] key_count_now = mbbs_pkg::KEY_COUNT_RESET;

  // search results still owed by the block, oldest first
  result_t pending_results [$];
  result_t no_typed = '{default: '0};

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 76;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  model_biased_binary_search_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // key_count of zero behaves as one entry, anything past the table as a full table
  function automatic int active_entries();
    if (key_count_now == '0) return 1;
    if (key_count_now > DEPTH) return DEPTH;
    return int'(key_count_now);
  endfunction

  // biased binary search over the shadow table
  function automatic result_t search_outcome(input query_t q);
    result_t          r;
    longint           lo_w;
    longint           hi_w;
    longint           probe;
    longint           last;
    logic [KEY_W-1:0] entry;
    bit               first_probe;
    bit               done;
    r.found       = 1'b0;
    r.position    = '0;
    r.probe_count = '0;
    lo_w          = q.low_bound;
    hi_w          = q.high_bound;
    last          = active_entries() - 1;
    first_probe   = 1'b1;
    done          = 1'b0;
    // the window test uses the raw bounds; clamping happens inside the loop
    while (!done && lo_w <= hi_w) begin
      if (lo_w < 0) lo_w = 0;
      if (hi_w > last) hi_w = last;
      if (first_probe) begin
        // first probe goes where the prediction says, even if the clamped window is empty
        first_probe = 1'b0;
        probe       = q.predicted_position;
        if (probe < 0) probe = 0;
        if (probe > last) probe = last;
      end else begin
        probe = lo_w + (hi_w - lo_w) / 2;
      end
      if (r.probe_count != mbbs_pkg::PROBE_MAX) r.probe_count = r.probe_count + 1'b1;
      entry = key_store[probe];
      if (entry == q.search_key) begin
        r.found    = 1'b1;
        r.position = probe[IDX_W-1:0];
        done       = 1'b1;
      end else if (entry < q.search_key) begin
        lo_w = probe + 1;
      end else begin
        hi_w = probe - 1;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // every field random; the fields a beat's mode does not use stay random too
  function automatic query_t noise_query(input logic mode);
    query_t q;
    q.mode               = mode;
    q.entry_index        = IDX_W'($urandom);
    q.entry_key          = rand_key();
    q.search_key         = rand_key();
    q.predicted_position = BOUND_W'($urandom);
    q.low_bound          = BOUND_W'($urandom);
    q.high_bound         = BOUND_W'($urandom);
    return q;
  endfunction

  // a search the way a learned index would issue it: a guess near the true slot
  // and an error window around the guess
  function automatic query_t shaped_search(input int n);
    query_t q;
    int     target;
    int     err;
    int     pred;
    int     slack;
    q      = noise_query(mbbs_pkg::MODE_SEARCH);
    target = $urandom_range(0, n - 1);
    // mostly hits; a key one above an entry is usually a miss
    if ($urandom_range(0, 3) == 0) q.search_key = key_store[target] + 1'b1;
    else q.search_key = key_store[target];
    err   = $urandom_range(0, (1 << $urandom_range(0, 12)) - 1);
    pred  = target + $urandom_range(0, 2 * err) - err;
    slack = $urandom_range(0, 3);
    q.predicted_position = BOUND_W'(pred);
    q.low_bound          = BOUND_W'(pred - err - slack);
    q.high_bound         = BOUND_W'(pred + err + slack);
    // now and then a window too tight to hold the target
    if ($urandom_range(0, 9) == 0) q.high_bound = BOUND_W'(pred - $urandom_range(0, 2));
    return q;
  endfunction

  function automatic stim_row_t load_row(input int idx, input logic [KEY_W-1:0] key);
    stim_row_t row;
    row.kind             = ROW_LOAD;
    row.count            = 0;
    row.beat             = noise_query(mbbs_pkg::MODE_LOAD);
    row.beat.entry_index = IDX_W'(idx);
    row.beat.entry_key   = key;
    row.typed            = 1'b0;
    row.want             = no_typed;
    return row;
  endfunction

  function automatic stim_row_t search_row(input logic [KEY_W-1:0] key, input int pred,
                                           input int lo, input int hi);
    stim_row_t row;
    row.kind                    = ROW_SEARCH;
    row.count                   = 0;
    row.beat                    = noise_query(mbbs_pkg::MODE_SEARCH);
    row.beat.search_key         = key;
    row.beat.predicted_position = BOUND_W'(pred);
    row.beat.low_bound          = BOUND_W'(lo);
    row.beat.high_bound         = BOUND_W'(hi);
    row.typed                   = 1'b0;
    row.want                    = no_typed;
    return row;
  endfunction

  function automatic stim_row_t with_result(input stim_row_t row, input logic found,
                                            input int pos, input int probes);
    stim_row_t r;
    r                  = row;
    r.typed            = 1'b1;
    r.want.found       = found;
    r.want.position    = IDX_W'(pos);
    r.want.probe_count = PRB_W'(probes);
    return r;
  endfunction

  function automatic stim_row_t count_row(input int value);
    stim_row_t row;
    row.kind  = ROW_KEY_COUNT;
    row.count = value;
    row.beat  = noise_query(mbbs_pkg::MODE_LOAD);
    row.typed = 1'b0;
    row.want  = no_typed;
    return row;
  endfunction

  // drive one beat at the falling edge, hold it until taken; the expectation
  // is worked out against the table as it stands at the accepting edge
  task automatic send_beat(input query_t q, input bit typed, input result_t want);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.mode;
    s_axis_tdata  <= {{(IN_TDATA_W - IDX_W - 2 * KEY_W - 3 * BOUND_W){1'b0}},
                      q.high_bound, q.low_bound, q.predicted_position,
                      q.search_key, q.entry_key, q.entry_index};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (q.mode == mbbs_pkg::MODE_LOAD) key_store[q.entry_index] = q.entry_key;
    else pending_results.push_back(typed ? want : search_outcome(q));
  endtask

  // one register access, setup phase then access phase; a read compares prdata with the given value
  task automatic apb_access(input logic wr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {mbbs_pkg::REG_KEY_COUNT, 2'b00};
    pwdata  <= wr ? data : 32'h0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (!wr && prdata !== data) begin
      $display("%0t: key_count readback expected %0h actual %0h", $time, data, prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // sender holds off until every owed result is out, then the block gets time to
  // finish a trailing load before the register is touched
  task automatic write_key_count(input int value);
    logic [KCNT_W-1:0] v;
    v = KCNT_W'(value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_access(1'b1, 32'(value));
    key_count_now = v;
    apb_access(1'b0, {{(32 - KCNT_W){1'b0}}, v});
  endtask

  // sorted keys into the first n slots; gaps shrink to zero sometimes, so
  // duplicates and a saturated all-ones tail show up too
  task automatic fill_sorted(input int n);
    logic [KEY_W-1:0] level;
    logic [KEY_W-1:0] step;
    query_t           q;
    level = rand_key() >> $urandom_range(0, 63);
    if ($urandom_range(0, 3) == 0) level = '0;
    for (int i = 0; i < n; i++) begin
      q             = noise_query(mbbs_pkg::MODE_LOAD);
      q.entry_index = IDX_W'(i);
      q.entry_key   = level;
      send_beat(q, 1'b0, no_typed);
      step  = rand_key() >> $urandom_range(20, 63);
      level = (level + step < level) ? '1 : level + step;
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver, checker, watchdog
  // --------------------------------------------------------------------------

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // every result beat is matched against the oldest owed result
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none owed: found %0b position %0d probes %0d",
                 $time, m_axis_tuser, m_axis_tdata[IDX_W-1:0],
                 m_axis_tdata[IDX_W+PRB_W-1:IDX_W]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.found ||
            m_axis_tdata[IDX_W-1:0] !== want.position ||
            m_axis_tdata[IDX_W+PRB_W-1:IDX_W] !== want.probe_count) begin
          $display("%0t: expected found %0b position %0d probes %0d,",
                   $time, want.found, want.position, want.probe_count,
                   " actual found %0b position %0d probes %0d", m_axis_tuser,
                   m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W+PRB_W-1:IDX_W]);
          mismatch_count++;
        end
      end
    end
  end

  // a run that stops moving ends here
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("tb_model_biased_binary_search_core: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------

  initial begin : stimulus
    stim_row_t rows [$];
    int        counts [RANDOM_PHASES];
    int        n;
    int        span;
    int        pick;
    query_t    q;

    // small four-entry table: smallest key, two middle keys, largest key
    rows.push_back(count_row(4));
    rows.push_back(load_row(0, 64'h0));
    rows.push_back(load_row(1, 64'd100));
    rows.push_back(load_row(2, 64'd200));
    rows.push_back(load_row(3, '1));
    // exact guess hits on the first probe
    rows.push_back(with_result(search_row(64'd100, 1, 0, 3), 1'b1, 1, 1));
    // raw window inverted: no probe at all
    rows.push_back(with_result(search_row(64'd100, 1, 5, 4), 1'b0, 0, 0));
    // extreme bounds and guesses, clamped into the table
    rows.push_back(search_row('1, -1048576, -1048576, 1048575));
    rows.push_back(search_row(64'h0, 1048575, -1048576, 1048575));
    // window past the table: clamps empty, the first probe still happens
    rows.push_back(search_row(64'd300, 3, 10, 20));
    // key between entries: full descent, not found
    rows.push_back(search_row(64'd150, 0, 0, 3));
    // single-slot window
    rows.push_back(with_result(search_row(64'd200, 2, 2, 2), 1'b1, 2, 1));
    // window wholly below zero still probes slot zero
    rows.push_back(with_result(search_row(64'h0, -7, -10, -5), 1'b1, 0, 1));
    // extremes swapped: empty window
    rows.push_back(with_result(search_row(64'd100, 0, 1048575, -1048576), 1'b0, 0, 0));
    // key_count of zero acts as one entry
    rows.push_back(count_row(0));
    rows.push_back(search_row(64'd100, 2, 0, 3));
    rows.push_back(with_result(search_row(64'h0, 3, 0, 3), 1'b1, 0, 1));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_KEY_COUNT) write_key_count(rows[i].count);
      else send_beat(rows[i].beat, rows[i].typed, rows[i].want);
    end

    // random phases; the first fills the leading slots, and where key_count reaches
    // past them the window and the guess are held inside the written slots
    counts = '{4096, 8191, 1, 0, 2, 17, 300, 4095, 1, 4096};
    counts[6] = $urandom_range(3, REFILL_MAX);
    counts[9] = $urandom_range(REFILL_MAX + 1, 8191);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // sender busy and receiver quiet, then swapped, then both flat out
      if (p == 4) begin
        send_idle_pct = 76;
        recv_idle_pct = 19;
      end else if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_key_count(counts[p]);
      n = active_entries();
      if (p == 0) fill_sorted(FILL_SPAN);
      else if (n <= REFILL_MAX) fill_sorted(n);
      span = (n < FILL_SPAN) ? n : FILL_SPAN;
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          q = shaped_search(span);
        end else if (pick < 90) begin
          q = noise_query(mbbs_pkg::MODE_SEARCH);
          if ($urandom_range(0, 1) == 1) q.search_key = key_store[$urandom_range(0, span - 1)];
        end else begin
          // stray load: any slot, any key, may break the ordering
          q = noise_query(mbbs_pkg::MODE_LOAD);
        end
        // keep every probe inside the written slots
        if (q.mode == mbbs_pkg::MODE_SEARCH && n > span) begin
          if (int'(q.predicted_position) > span - 1) q.predicted_position = BOUND_W'(span - 1);
          if (int'(q.high_bound) > span - 1) q.high_bound = BOUND_W'(span - 1);
        end
        send_beat(q, 1'b0, no_typed);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_model_biased_binary_search_core: done, clean");
    end else begin
      $display("tb_model_biased_binary_search_core: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/mbbs_pkg.sv
src/mbbs_ctrl.sv
src/mbbs_dp.sv
src/model_biased_binary_search_core.sv
tb/sv/tb_model_biased_binary_search_core.sv
